@@ rtl/rtc_pkg.sv @@
// Shared types, widths and constants for the RGB to CMYK percent converter.
`default_nettype none

package rtc_pkg;

	localparam int ChanW     = 8;
	localparam int PctW      = 7;
	localparam int Lanes     = 4;
	localparam int NumW      = 16;
	localparam int DenW      = ChanW + 1;
	localparam int QuotBits  = PctW;
	localparam int FifoDepth = 4;

	localparam int LaneCyan    = 0;
	localparam int LaneMagenta = 1;
	localparam int LaneYellow  = 2;
	localparam int LaneBlack   = 3;

	localparam logic [ChanW-1:0] ChanMax = 8'd255;
	localparam logic [PctW-1:0]  PctFull = 7'd100;

	typedef struct packed {
		logic [ChanW-1:0] red_in;
		logic [ChanW-1:0] green_in;
		logic [ChanW-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [PctW-1:0] cyan_pct;
		logic [PctW-1:0] magenta_pct;
		logic [PctW-1:0] yellow_pct;
		logic [PctW-1:0] black_pct;
	} ink_t;

	// One division job per lane: quotient = num / den, with num = 200*n + d, den = 2*d.
	typedef struct packed {
		logic                           zero;
		logic [Lanes-1:0][NumW-1:0]     num;
		logic [Lanes-1:0][DenW-1:0]     den;
	} job_t;

	// Per-stage state of the restoring divider.
	typedef struct packed {
		logic                           zero;
		logic [Lanes-1:0][NumW-1:0]     rem;
		logic [Lanes-1:0][DenW-1:0]     den;
		logic [Lanes-1:0][PctW-1:0]     quo;
	} div_stage_t;

endpackage

`default_nettype wire

@@ rtl/rtc_front.sv @@
// Front stage: take a pixel, find the largest channel and build the four division jobs.
`default_nettype none

module rtc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire rtc_pkg::pixel_t pixel,
	output logic                 job_vld,
	input  wire logic            job_rdy,
	output rtc_pkg::job_t        job
);

	logic                         vld_s1;
	rtc_pkg::job_t                job_s1;
	rtc_pkg::job_t                job_c;
	logic                         adv;
	logic [rtc_pkg::ChanW-1:0]    mx;
	logic [rtc_pkg::ChanW-1:0]    n_c [rtc_pkg::Lanes];
	logic [rtc_pkg::ChanW-1:0]    d_c [rtc_pkg::Lanes];

	// num = 200*n + d built from shifts
	function automatic logic [rtc_pkg::NumW-1:0] num_of(
		input logic [rtc_pkg::ChanW-1:0] n,
		input logic [rtc_pkg::ChanW-1:0] d
	);
		logic [rtc_pkg::NumW-1:0] nw;
		logic [rtc_pkg::NumW-1:0] dw;
		nw = rtc_pkg::NumW'(n);
		dw = rtc_pkg::NumW'(d);
		return (nw << 7) + (nw << 6) + (nw << 3) + dw;
	endfunction

	always_comb begin
		mx = pixel.red_in;
		if (pixel.green_in > mx) begin
			mx = pixel.green_in;
		end
		if (pixel.blue_in > mx) begin
			mx = pixel.blue_in;
		end

		n_c[rtc_pkg::LaneCyan]    = mx - pixel.red_in;
		n_c[rtc_pkg::LaneMagenta] = mx - pixel.green_in;
		n_c[rtc_pkg::LaneYellow]  = mx - pixel.blue_in;
		n_c[rtc_pkg::LaneBlack]   = rtc_pkg::ChanMax - mx;
		d_c[rtc_pkg::LaneCyan]    = mx;
		d_c[rtc_pkg::LaneMagenta] = mx;
		d_c[rtc_pkg::LaneYellow]  = mx;
		d_c[rtc_pkg::LaneBlack]   = rtc_pkg::ChanMax;

		job_c.zero = (mx == '0);
		for (int l = 0; l < rtc_pkg::Lanes; l++) begin
			job_c.num[l] = num_of(n_c[l], d_c[l]);
			job_c.den[l] = {d_c[l], 1'b0};
		end
	end

	assign adv  = !vld_s1 || job_rdy;
	assign full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			job_s1 <= job_c;
		end
	end

	assign job_vld = vld_s1;
	assign job     = job_s1;

endmodule

`default_nettype wire

@@ rtl/rtc_fifo.sv @@
// Short job queue between the front stage and the divider pipeline.
`default_nettype none

module rtc_fifo #(
	parameter int Depth = rtc_pkg::FifoDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_vld,
	output logic               wr_rdy,
	input  wire rtc_pkg::job_t wr_data,
	output logic               rd_vld,
	input  wire logic          rd_en,
	output rtc_pkg::job_t      rd_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	rtc_pkg::job_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            wr;
	logic            rd;

	assign wr_rdy  = (cnt_q != CntW'(Depth));
	assign rd_vld  = (cnt_q != '0);
	assign wr      = wr_vld && wr_rdy;
	assign rd      = rd_en && rd_vld;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("job queue count exceeds depth");

	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_vld)
		else $error("divider took a job from an empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/rtc_div.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, four lanes.
`default_nettype none

module rtc_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_vld,
	output logic               job_take,
	input  wire rtc_pkg::job_t job,
	output logic               empty,
	input  wire logic          pop,
	output rtc_pkg::ink_t      ink
);

	localparam int Stages = rtc_pkg::QuotBits;

	logic [Stages:1]      vld_s;
	rtc_pkg::div_stage_t  stg_s [1:Stages];
	rtc_pkg::div_stage_t  stage0;
	rtc_pkg::div_stage_t  last;
	logic                 adv;

	// Whole pipeline moves together; it holds only while a result waits unread.
	assign adv      = !vld_s[Stages] || pop;
	assign job_take = adv && job_vld;

	always_comb begin
		stage0.zero = job.zero;
		stage0.rem  = job.num;
		stage0.den  = job.den;
		stage0.quo  = '0;
	end

	for (genvar k = 1; k <= Stages; k++) begin : g_stage
		localparam int Bit = Stages - k;

		rtc_pkg::div_stage_t src;
		rtc_pkg::div_stage_t nxt;
		logic                src_vld;

		if (k == 1) begin : g_first
			assign src     = stage0;
			assign src_vld = job_vld;
		end else begin : g_next
			assign src     = stg_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		always_comb begin
			logic [rtc_pkg::NumW-1:0] sh;
			nxt = src;
			for (int l = 0; l < rtc_pkg::Lanes; l++) begin
				sh = rtc_pkg::NumW'(src.den[l]) << Bit;
				if (src.rem[l] >= sh) begin
					nxt.rem[l]      = src.rem[l] - sh;
					nxt.quo[l][Bit] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_s[k] <= nxt;
			end
		end
	end

	assign last  = stg_s[Stages];
	assign empty = !vld_s[Stages];

	// Drop the chromatic quotients of a pure black pixel: they had no divisor.
	always_comb begin
		ink.cyan_pct    = last.zero ? '0 : last.quo[rtc_pkg::LaneCyan];
		ink.magenta_pct = last.zero ? '0 : last.quo[rtc_pkg::LaneMagenta];
		ink.yellow_pct  = last.zero ? '0 : last.quo[rtc_pkg::LaneYellow];
		ink.black_pct   = last.quo[rtc_pkg::LaneBlack];
	end

`ifndef SYNTHESIS
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (ink.cyan_pct <= rtc_pkg::PctFull) && (ink.magenta_pct <= rtc_pkg::PctFull)
			&& (ink.yellow_pct <= rtc_pkg::PctFull) && (ink.black_pct <= rtc_pkg::PctFull))
		else $error("ink percentage above full scale");

	a_black_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last.zero) |-> (ink.black_pct == rtc_pkg::PctFull))
		else $error("pure black pixel without full black ink");
`endif

endmodule

`default_nettype wire

@@ rtl/rgb_to_cmyk_percent.sv @@
// Top level of the RGB to CMYK percent converter: front stage, job queue, divider pipeline.
//
//   channel   direction  handshake              payload
//   pixel     in         push / full            rtc_pkg::pixel_t (red_in, green_in, blue_in)
//   ink       out        pop / empty            rtc_pkg::ink_t (cyan, magenta, yellow, black)
//
// Throughput is one pixel per clock while pop keeps up.
// Path from the input transfer to the result showing on ink: the front register loads at
// the transfer edge, the queue write follows, and the job then passes through seven
// registered divider stages (one quotient bit each).
// Reset (arst_n low) empties the front stage, the queue and the divider pipeline.
// A result left unread holds the divider; the queue then absorbs up to Depth more jobs and
// the front register one more before full rises, so the input side keeps taking pixels.
`default_nettype none

module rgb_to_cmyk_percent #(
	parameter int Depth = rtc_pkg::FifoDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire rtc_pkg::pixel_t pixel,
	output logic                 empty,
	input  wire logic            pop,
	output rtc_pkg::ink_t        ink
);

	// front stage to queue
	logic          fr_vld;
	logic          fr_rdy;
	rtc_pkg::job_t fr_job;

	// queue to divider
	logic          q_vld;
	logic          q_take;
	rtc_pkg::job_t q_job;

	// Find the largest channel, flag pure black, build numerators and divisors.
	rtc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.job_vld (fr_vld),
		.job_rdy (fr_rdy),
		.job     (fr_job)
	);

	// Hold jobs while the divider waits on the result side.
	rtc_fifo #(
		.Depth (Depth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (fr_vld),
		.wr_rdy  (fr_rdy),
		.wr_data (fr_job),
		.rd_vld  (q_vld),
		.rd_en   (q_take),
		.rd_data (q_job)
	);

	// Advance all four lanes through the restoring divider and present the result.
	rtc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_vld  (q_vld),
		.job_take (q_take),
		.job      (q_job),
		.empty    (empty),
		.pop      (pop),
		.ink      (ink)
	);

endmodule

`default_nettype wire
